// File: rtl/core/aldg_pkg.sv
package aldg_pkg;

  // key store geometry
  localparam int unsigned MAX_KEY   = 4096;
  localparam int unsigned KEY_AW    = $clog2(MAX_KEY);
  localparam int unsigned KPOS_W    = KEY_AW + 1;
  localparam int unsigned MEM_DEPTH = 2 * MAX_KEY;

  // command queue between front and back
  localparam int unsigned CQ_DEPTH  = 4;
  localparam int unsigned CQ_AW     = $clog2(CQ_DEPTH);

  // input op codes
  localparam logic [1:0] OP_CHAR = 2'd0;
  localparam logic [1:0] OP_EOL  = 2'd1;
  localparam logic [1:0] OP_EOI  = 2'd2;

  // output modes
  localparam logic [2:0] MODE_COUNT  = 3'd1;
  localparam logic [2:0] MODE_ALLREP = 3'd2;
  localparam logic [2:0] MODE_REP    = 3'd3;
  localparam logic [2:0] MODE_UNIQ   = 3'd4;

  // register indexes
  localparam logic [2:0] REG_FIELDS = 3'd0;
  localparam logic [2:0] REG_CHARS  = 3'd1;
  localparam logic [2:0] REG_LIMIT  = 3'd2;
  localparam logic [2:0] REG_FOLD   = 3'd3;
  localparam logic [2:0] REG_MODE   = 3'd4;

  localparam logic [7:0]  SPACE_CHAR = 8'h20;
  localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_KEY = 2'd0,
    CMD_EOL = 2'd1,
    CMD_EOI = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [31:0] group_count;
    logic [31:0] copies;
    logic        show_count;
    logic [31:0] first_line;
    logic        key_truncated;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  fields_to_skip;
    logic [15:0] chars_to_skip;
    logic [12:0] key_limit;
    logic        fold_case;
    logic [2:0]  out_mode;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [KPOS_W-1:0] pos;
    logic [7:0]        char_code;
    logic              trunc;
  } cmd_t;

  function automatic logic [7:0] fold_char(logic en, logic [7:0] c);
    if (en && c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

endpackage

// File: rtl/core/aldg_front.sv
module aldg_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  aldg_pkg::cfg_t    cfg_i,
  input  logic              push,
  output logic              full,
  input  aldg_pkg::in_item_t in_item_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output aldg_pkg::cmd_t    cmd_o
);
  import aldg_pkg::*;

  logic [7:0]        fs_q, fs_d;
  logic              inw_q, inw_d;
  logic [15:0]       cs_q, cs_d;
  logic [KPOS_W-1:0] kp_q, kp_d;
  logic              tr_q, tr_d;
  logic              acc;
  logic              to_chars, to_key, in_window;
  logic [7:0]        fs_inc;

  assign full = !cmd_ready_i;
  assign acc  = push && cmd_ready_i;
  assign fs_inc = fs_q + 8'd1;
  assign in_window = (cfg_i.key_limit == '0) || (kp_q < cfg_i.key_limit);

  // classify one item
  always_comb begin
    fs_d = fs_q; inw_d = inw_q; cs_d = cs_q; kp_d = kp_q; tr_d = tr_q;
    to_chars = 1'b0; to_key = 1'b0;
    cmd_valid_o = 1'b0;
    cmd_o.kind = CMD_KEY;
    cmd_o.pos = kp_q;
    cmd_o.char_code = in_item_i.char_code;
    cmd_o.trunc = tr_q;
    case (in_item_i.op)
      OP_CHAR: begin
        // field skipping
        if (fs_q < cfg_i.fields_to_skip) begin
          if (in_item_i.char_code > SPACE_CHAR) begin
            inw_d = 1'b1;
          end else if (inw_q) begin
            inw_d = 1'b0;
            fs_d = fs_inc;
            to_chars = !(fs_inc < cfg_i.fields_to_skip);
          end
        end else begin
          to_chars = 1'b1;
        end
        // char skipping
        if (to_chars) begin
          if (cs_q < cfg_i.chars_to_skip) begin
            cs_d = cs_q + 16'd1;
          end else begin
            to_key = 1'b1;
          end
        end
        // key byte
        if (to_key && in_window) begin
          if (kp_q >= KPOS_W'(MAX_KEY)) begin
            tr_d = 1'b1;
          end else begin
            cmd_valid_o = push;
            kp_d = kp_q + KPOS_W'(1);
          end
        end
      end
      OP_EOL: begin
        cmd_valid_o = push;
        cmd_o.kind = CMD_EOL;
        fs_d = '0; inw_d = 1'b0; cs_d = '0; kp_d = '0; tr_d = 1'b0;
      end
      OP_EOI: begin
        cmd_valid_o = push;
        cmd_o.kind = CMD_EOI;
        fs_d = '0; inw_d = 1'b0; cs_d = '0; kp_d = '0; tr_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q <= '0; inw_q <= 1'b0; cs_q <= '0; kp_q <= '0; tr_q <= 1'b0;
    end else if (acc) begin
      fs_q <= fs_d; inw_q <= inw_d; cs_q <= cs_d; kp_q <= kp_d; tr_q <= tr_d;
    end
  end

endmodule

// File: rtl/core/aldg_cmdq.sv
module aldg_cmdq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  aldg_pkg::cmd_t wr_cmd_i,
  output logic           rd_valid_o,
  input  logic           rd_pop_i,
  output aldg_pkg::cmd_t rd_cmd_o
);
  import aldg_pkg::*;

  cmd_t            ent_q [CQ_DEPTH];
  logic [CQ_AW-1:0] wp_q, rp_q;
  logic [CQ_AW:0]   cnt_q;
  logic             wr, rd;

  assign wr_ready_o = cnt_q != (CQ_AW+1)'(CQ_DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign rd_cmd_o   = ent_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_pop_i && rd_valid_o;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (wr) begin
      ent_q[wp_q] <= wr_cmd_i;
    end
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + CQ_AW'(1);
      if (rd) rp_q <= rp_q + CQ_AW'(1);
      cnt_q <= cnt_q + (CQ_AW+1)'(wr) - (CQ_AW+1)'(rd);
    end
  end

endmodule

// File: rtl/core/aldg_back.sv
module aldg_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  aldg_pkg::cfg_t      cfg_i,
  input  logic                cmd_valid_i,
  output logic                cmd_pop_o,
  input  aldg_pkg::cmd_t      cmd_i,
  output logic                empty,
  input  logic                pop,
  output aldg_pkg::out_item_t out_item_o
);
  import aldg_pkg::*;

  logic [7:0]        mem [MEM_DEPTH];
  logic [7:0]        rdata_q;
  logic              bv_q;
  cmd_t              bc_q;
  logic              adv, go, emit, diff, start;
  logic              bank_q, bank_d;
  logic              have_q;
  logic [31:0]       lines_q, lc_q, start_q;
  logic [KPOS_W-1:0] gkl_q;
  logic              tseen_q, ldiff_q;
  logic [KEY_AW-1:0] kaddr;
  out_item_t         rec;
  out_item_t         of_q [2];
  logic              ofw_q, ofr_q;
  logic [1:0]        ofc_q;
  logic              of_full, of_wr, of_rd;

  // stage b decision
  assign diff  = ldiff_q || (have_q && bc_q.pos != gkl_q);
  assign start = bv_q && bc_q.kind == CMD_EOL && (!have_q || diff);
  assign emit  = bv_q && have_q &&
                 ((bc_q.kind == CMD_EOL && diff) || bc_q.kind == CMD_EOI);
  assign of_full = ofc_q == 2'd2;
  assign go      = !(emit && of_full);
  assign adv     = !bv_q || go;
  assign cmd_pop_o = adv && cmd_valid_i;
  assign bank_d  = start ? !bank_q : bank_q;
  assign kaddr   = cmd_i.pos[KEY_AW-1:0];

  // key store: write current bank, read the group's bank
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && cmd_i.kind == CMD_KEY) begin
      mem[{bank_d, kaddr}] <= cmd_i.char_code;
    end
    if (adv) begin
      rdata_q <= mem[{!bank_d, kaddr}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) bc_q <= cmd_i;
  end

  // decision record
  always_comb begin
    rec.group_count   = lines_q;
    rec.copies        = 32'd1;
    rec.show_count    = 1'b0;
    rec.first_line    = start_q;
    rec.key_truncated = tseen_q;
    case (cfg_i.out_mode)
      MODE_COUNT:  rec.show_count = 1'b1;
      MODE_ALLREP: rec.copies = (lines_q > 32'd1) ? lines_q : 32'd0;
      MODE_REP:    rec.copies = (lines_q > 32'd1) ? 32'd1 : 32'd0;
      MODE_UNIQ:   rec.copies = (lines_q > 32'd1) ? 32'd0 : 32'd1;
      default:     rec.copies = 32'd1;
    endcase
  end

  // group state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= 1'b0; bank_q <= 1'b0; have_q <= 1'b0; lines_q <= '0;
      lc_q <= '0; start_q <= '0; gkl_q <= '0; tseen_q <= 1'b0; ldiff_q <= 1'b0;
    end else begin
      if (adv) bv_q <= cmd_valid_i;
      if (bv_q && go) begin
        bank_q <= bank_d;
        case (bc_q.kind)
          CMD_KEY: begin
            if (have_q && (bc_q.pos >= gkl_q ||
                fold_char(cfg_i.fold_case, rdata_q) !=
                fold_char(cfg_i.fold_case, bc_q.char_code))) begin
              ldiff_q <= 1'b1;
            end
          end
          CMD_EOL: begin
            if (start) begin
              have_q <= 1'b1; lines_q <= 32'd1; start_q <= lc_q;
              tseen_q <= bc_q.trunc; gkl_q <= bc_q.pos;
            end else begin
              if (lines_q != COUNT_MAX) lines_q <= lines_q + 32'd1;
              tseen_q <= tseen_q | bc_q.trunc;
            end
            lc_q <= lc_q + 32'd1;
            ldiff_q <= 1'b0;
          end
          CMD_EOI: begin
            have_q <= 1'b0; lines_q <= '0; gkl_q <= '0; start_q <= '0;
            tseen_q <= 1'b0; lc_q <= '0; ldiff_q <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // output queue
  assign of_wr = emit && go;
  assign of_rd = pop && !empty;
  assign empty = ofc_q == 2'd0;
  assign out_item_o = of_q[ofr_q];

  always_ff @(posedge clk_i) begin
    if (of_wr) of_q[ofw_q] <= rec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofw_q <= 1'b0; ofr_q <= 1'b0; ofc_q <= '0;
    end else begin
      if (of_wr) ofw_q <= !ofw_q;
      if (of_rd) ofr_q <= !ofr_q;
      ofc_q <= ofc_q + 2'(of_wr) - 2'(of_rd);
    end
  end

  a_lines_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_q |-> lines_q != '0) else $error("open group with no lines");
  a_no_group_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !have_q |-> (lines_q == '0 && gkl_q == '0)) else $error("stale group state");
  a_of_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ofc_q != 2'd3) else $error("output queue overflow");
  a_bank_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bv_q && go && start) |=> bank_q != $past(bank_q)) else $error("bank not flipped");

endmodule

// File: rtl/core/adjacent_line_dedup_grouper_core.sv
// channel  | direction | handshake          | payload
// input    | in        | push / full        | in_item_i (op, char_code)
// result   | out       | empty / pop        | out_item_o (decision record)
// config   | in/out    | psel/penable/pready | paddr, pwdata, prdata
//
// one item taken per cycle unless full; a result is queued once its group closes
// the front classifies bytes, a 4-entry command queue feeds the key store unit
// the key store does one write and one read per cycle, which sets the rate
// reset clears all control state; the key store needs no clearing
// full rises when the command queue fills, which happens only while results wait
module adjacent_line_dedup_grouper_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  aldg_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output aldg_pkg::out_item_t out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import aldg_pkg::*;

  cfg_t       cfg_q;
  logic       f_valid, q_ready, q_valid, q_pop, cfg_wr;
  cmd_t       f_cmd, q_cmd;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];
  assign cfg_wr = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      case (ridx)
        REG_FIELDS: cfg_q.fields_to_skip <= pwdata[7:0];
        REG_CHARS:  cfg_q.chars_to_skip  <= pwdata[15:0];
        REG_LIMIT:  cfg_q.key_limit      <= pwdata[12:0];
        REG_FOLD:   cfg_q.fold_case      <= pwdata[0];
        REG_MODE:   cfg_q.out_mode       <= pwdata[2:0];
        default: begin
        end
      endcase
    end
  end

  // register reads
  always_comb begin
    case (ridx)
      REG_FIELDS: prdata = {24'd0, cfg_q.fields_to_skip};
      REG_CHARS:  prdata = {16'd0, cfg_q.chars_to_skip};
      REG_LIMIT:  prdata = {19'd0, cfg_q.key_limit};
      REG_FOLD:   prdata = {31'd0, cfg_q.fold_case};
      REG_MODE:   prdata = {29'd0, cfg_q.out_mode};
      default:    prdata = '0;
    endcase
  end

  aldg_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .push, .full, .in_item_i,
    .cmd_valid_o(f_valid), .cmd_ready_i(q_ready), .cmd_o(f_cmd)
  );

  aldg_cmdq u_cmdq (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_ready_o(q_ready), .wr_cmd_i(f_cmd),
    .rd_valid_o(q_valid), .rd_pop_i(q_pop), .rd_cmd_o(q_cmd)
  );

  aldg_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .cmd_valid_i(q_valid), .cmd_pop_o(q_pop),
    .cmd_i(q_cmd), .empty, .pop, .out_item_o
  );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import aldg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned DIRECTED_PHASES = 2;

  // register indexes as used by the testbench (same values as the package)
  typedef enum int {
    R_FIELDS = 0,
    R_CHARS  = 1,
    R_LIMIT  = 2,
    R_FOLD   = 3,
    R_MODE   = 4
  } reg_idx_e;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  in_item_t    in_item;
  logic        empty;
  logic        pop;
  out_item_t   out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  adjacent_line_dedup_grouper_core i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // uniq model state
  logic [7:0]  key_mem [0:2*MAX_KEY-1];
  logic        bank;
  int unsigned grp_key_len;
  int unsigned key_pos;
  int unsigned fld_done;
  logic        in_word;
  int unsigned chr_done;
  logic        differs;
  logic        grp_open;
  logic [31:0] grp_lines;
  logic [31:0] line_num;
  logic [31:0] grp_first;
  logic        grp_trunc;
  logic        ln_trunc;

  // shadow configuration
  logic [7:0]  cfg_fields;
  logic [15:0] cfg_chars;
  logic [12:0] cfg_limit;
  logic        cfg_fold;
  logic [2:0]  cfg_mode;

  in_item_t    pending_items[$];
  out_item_t   expected_records[$];
  int          error_count;
  int          records_seen;
  int unsigned cycle_count;

  function automatic logic [7:0] lower(logic [7:0] c);
    if (cfg_fold && c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
    return c;
  endfunction

  function automatic out_item_t group_record();
    out_item_t r;
    logic      dup;
    dup = grp_lines > 1;
    r.group_count = grp_lines;
    r.copies = 32'd1;
    r.show_count = 1'b0;
    case (cfg_mode)
      MODE_COUNT:  r.show_count = 1'b1;
      MODE_ALLREP: r.copies = dup ? grp_lines : 32'd0;
      MODE_REP:    r.copies = dup ? 32'd1 : 32'd0;
      MODE_UNIQ:   r.copies = dup ? 32'd0 : 32'd1;
      default: ;
    endcase
    r.first_line = grp_first;
    r.key_truncated = grp_trunc;
    return r;
  endfunction

  function automatic void clear_line_state();
    key_pos = 0;
    fld_done = 0;
    in_word = 1'b0;
    chr_done = 0;
    differs = 1'b0;
    ln_trunc = 1'b0;
  endfunction

  function automatic void open_group();
    grp_open = 1'b1;
    grp_lines = 32'd1;
    grp_first = line_num;
    grp_trunc = ln_trunc;
    grp_key_len = key_pos;
    bank = ~bank;
  endfunction

  function automatic void take_key_byte(logic [7:0] c);
    int unsigned other;
    other = bank ? 0 : MAX_KEY;
    if (cfg_limit != 0 && key_pos >= cfg_limit) return;
    if (key_pos >= MAX_KEY) begin
      ln_trunc = 1'b1;
      return;
    end
    key_mem[(bank ? MAX_KEY : 0) + key_pos] = c;
    if (grp_open) begin
      if (key_pos >= grp_key_len) differs = 1'b1;
      else if (lower(key_mem[other + key_pos]) != lower(c)) differs = 1'b1;
    end
    key_pos++;
  endfunction

  // advance the model by one item and queue any decision record
  function automatic void predict_item(in_item_t it);
    logic [7:0] c;
    c = it.char_code;
    case (it.op)
      OP_CHAR: begin
        if (fld_done < cfg_fields) begin
          if (c > SPACE_CHAR) begin
            in_word = 1'b1;
            return;
          end
          if (!in_word) return;
          in_word = 1'b0;
          fld_done++;
          if (fld_done < cfg_fields) return;
        end
        if (chr_done < cfg_chars) begin
          chr_done++;
          return;
        end
        take_key_byte(c);
      end
      OP_EOL: begin
        if (grp_open && key_pos != grp_key_len) differs = 1'b1;
        if (!grp_open) begin
          open_group();
        end else if (!differs) begin
          if (grp_lines != COUNT_MAX) grp_lines++;
          grp_trunc |= ln_trunc;
        end else begin
          expected_records.push_back(group_record());
          open_group();
        end
        line_num++;
        clear_line_state();
      end
      OP_EOI: begin
        if (grp_open) expected_records.push_back(group_record());
        grp_open = 1'b0;
        grp_lines = 0;
        grp_key_len = 0;
        grp_first = 0;
        grp_trunc = 1'b0;
        line_num = 0;
        clear_line_state();
      end
      default: ;
    endcase
  endfunction

  // driver: feeds items from the pending queue with random gaps
  int unsigned push_gap;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      push <= 1'b0;
      in_item <= '0;
      push_gap <= 0;
    end else begin
      if (push && !full) begin
        predict_item(in_item);
        void'(pending_items.pop_front());
      end
      if (push && full) begin
        // hold the item
      end else if (push_gap != 0) begin
        push_gap <= push_gap - 1;
        push <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_item <= pending_items[0];
        push <= 1'b1;
        push_gap <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 14);
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor: pops records with random stalls and checks them
  int unsigned pop_gap;
  always @(posedge clk or negedge rst_n) begin
    out_item_t   exp_rec;
    int unsigned gap_draw;
    if (!rst_n) begin
      pop <= 1'b0;
      pop_gap <= 0;
    end else begin
      if (pop && !empty) begin
        records_seen++;
        if (expected_records.size() == 0) begin
          $error("unexpected record: count %0d first_line %0d",
                 out_item.group_count, out_item.first_line);
          error_count++;
        end else begin
          exp_rec = expected_records.pop_front();
          if (out_item.group_count !== exp_rec.group_count) begin
            $error("group_count exp %0d got %0d", exp_rec.group_count,
                   out_item.group_count);
            error_count++;
          end
          if (out_item.copies !== exp_rec.copies) begin
            $error("copies exp %0d got %0d", exp_rec.copies, out_item.copies);
            error_count++;
          end
          if (out_item.show_count !== exp_rec.show_count) begin
            $error("show_count exp %0d got %0d", exp_rec.show_count,
                   out_item.show_count);
            error_count++;
          end
          if (out_item.first_line !== exp_rec.first_line) begin
            $error("first_line exp %0d got %0d", exp_rec.first_line,
                   out_item.first_line);
            error_count++;
          end
          if (out_item.key_truncated !== exp_rec.key_truncated) begin
            $error("key_truncated exp %0d got %0d", exp_rec.key_truncated,
                   out_item.key_truncated);
            error_count++;
          end
        end
        gap_draw = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 14);
        pop_gap <= gap_draw;
        pop <= (gap_draw == 0);
      end else if (pop_gap != 0) begin
        pop_gap <= pop_gap - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic reg_write(reg_idx_e idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(4 * idx);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      R_FIELDS: cfg_fields = value[7:0];
      R_CHARS:  cfg_chars = value[15:0];
      R_LIMIT:  cfg_limit = value[12:0];
      R_FOLD:   cfg_fold = value[0];
      R_MODE:   cfg_mode = value[2:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int f, int c, int l, int fc, int m);
    reg_write(R_FIELDS, f);
    reg_write(R_CHARS, c);
    reg_write(R_LIMIT, l);
    reg_write(R_FOLD, fc);
    reg_write(R_MODE, m);
  endtask

  // wait until every queued item went in and every record came out
  task automatic drain();
    while (pending_items.size() != 0 || push || expected_records.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void add_item(logic [1:0] op, logic [7:0] c);
    in_item_t it;
    it.op = op;
    it.char_code = c;
    pending_items.push_back(it);
  endfunction

  function automatic void add_line(string s);
    foreach (s[i]) add_item(OP_CHAR, s[i]);
    add_item(OP_EOL, 8'h00);
  endfunction

  // random line from a small alphabet so neighbors often match
  function automatic void add_random_line(int unsigned seed_len, logic [7:0] pat[]);
    int unsigned n;
    n = seed_len;
    for (int unsigned i = 0; i < n; i++) add_item(OP_CHAR, pat[i]);
    add_item(OP_EOL, 8'($urandom));
  endfunction

  function automatic void random_phase(int unsigned n_lines, bit wild);
    logic [7:0]  pat[];
    int unsigned len;
    pat = new[12];
    len = 0;
    for (int unsigned k = 0; k < n_lines; k++) begin
      // repeat the previous line, flip the case of one byte, or make a fresh one
      if ($urandom_range(0, 2) == 0 || k == 0) begin
        len = $urandom_range(0, 12);
        foreach (pat[i]) begin
          case ($urandom_range(0, 5))
            0: pat[i] = 8'h20;
            1: pat[i] = $urandom_range(0, 1) ? 8'h41 : 8'h61;
            2: pat[i] = $urandom_range(0, 1) ? 8'h5A : 8'h7A;
            3: pat[i] = wild ? 8'($urandom) : 8'h09;
            default: pat[i] = 8'h62;
          endcase
        end
      end else if ($urandom_range(0, 4) == 0) begin
        // same length, case flipped in one byte
        if (len != 0) pat[$urandom_range(0, len - 1)] ^= 8'h20;
      end
      add_random_line(len, pat);
      if ($urandom_range(0, 40) == 0) add_item(2'd3, 8'($urandom));
      if ($urandom_range(0, 30) == 0) add_item(OP_EOI, 8'($urandom));
    end
    if ($urandom_range(0, 1)) add_item(OP_CHAR, 8'h55);
    add_item(OP_EOI, 8'h00);
  endfunction

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    error_count = 0;
    records_seen = 0;
    cycle_count = 0;
    cfg_fields = 0;
    cfg_chars = 0;
    cfg_limit = 0;
    cfg_fold = 0;
    cfg_mode = 0;
    bank = 1'b0;
    grp_key_len = 0;
    grp_open = 1'b0;
    grp_lines = 0;
    line_num = 0;
    grp_first = 0;
    grp_trunc = 1'b0;
    clear_line_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: defaults, empty lines, byte extremes, ignored op, eoi
    add_line("");
    add_line("");
    add_item(OP_CHAR, 8'h00);
    add_item(OP_EOL, 8'h00);
    add_item(OP_CHAR, 8'hFF);
    add_item(2'd3, 8'hFF);
    add_item(OP_EOL, 8'hFF);
    add_line("Ab");
    add_line("aB");
    add_item(OP_CHAR, 8'h41);
    add_item(OP_EOI, 8'h00);
    add_item(OP_EOI, 8'h00);
    drain();

    // fold case, skip fields and chars, count prefix
    set_config(1, 1, 3, 1, MODE_COUNT);
    add_line("x1 QABC");
    add_line("yy\tqabd");
    add_line("zz");
    add_item(OP_EOI, 8'h00);
    drain();

    // random phases across modes including undefined ones and extremes
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: set_config(0, 0, 0, 0, MODE_REP);
        1: set_config(255, 65535, 4096, 1, MODE_UNIQ);
        2: set_config(1, 2, 8191, 1, 7);
        3: set_config(2, 0, 1, 0, 5);
        default: set_config($urandom_range(0, 2), $urandom_range(0, 3),
                            $urandom_range(0, 6), $urandom_range(0, 1),
                            $urandom_range(0, 7));
      endcase
      random_phase(9, ph[0]);
      drain();
    end

    $display("ran %0d directed and random phases, %0d decision records checked",
             DIRECTED_PHASES + RANDOM_PHASES, records_seen);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
